[src/tmcg_pkg.sv]
`timescale 1ns / 1ps

package tmcg_pkg;

	// Raster geometry
	localparam int COLUMNS        = 40;
	localparam int ROWS           = 25;
	localparam int LINES_PER_CHAR = 8;

	// Memory sizes
	localparam int SCREEN_WORDS = 1024;
	localparam int GLYPH_WORDS  = 2048;
	localparam int SCR_AW       = $clog2(SCREEN_WORDS);
	localparam int GLYPH_AW     = $clog2(GLYPH_WORDS);
	localparam int CLR_W        = $clog2(SCREEN_WORDS + 1);

	// Field widths
	localparam int CMD_W  = 2;
	localparam int ADDR_W = 11;
	localparam int DATA_W = 8;
	localparam int COL_W  = 6;
	localparam int LINE_W = 3;
	localparam int ROW_W  = 5;
	localparam int PROW_W = ROW_W + LINE_W;
	localparam int CELL_W = $clog2(ROWS * COLUMNS);

	// Character code layout: low bits select the glyph, top bit inverts
	localparam int GLYPH_SEL_W = 7;
	localparam int INVERT_BIT  = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_SCREEN = 2'd1,
		CMD_GLYPH  = 2'd2
	} cmd_t;

	typedef logic [SCR_AW-1:0]   screen_addr_t;
	typedef logic [GLYPH_AW-1:0] glyph_addr_t;
	typedef logic [CELL_W-1:0]   cell_t;

	// Raster position handed from the position counters to the pipeline
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [LINE_W-1:0] line;
		logic [ROW_W-1:0]  row;
		cell_t             cell_addr;
	} pos_t;

endpackage

[src/tmcg_ram.sv]
`timescale 1ns / 1ps

module tmcg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; a read beside a write returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/tmcg_raster.sv]
`timescale 1ns / 1ps

module tmcg_raster (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	output tmcg_pkg::pos_t  pos
);

	logic [tmcg_pkg::COL_W-1:0]  col_q;
	logic [tmcg_pkg::LINE_W-1:0] line_q;
	logic [tmcg_pkg::ROW_W-1:0]  row_q;
	tmcg_pkg::cell_t             base_q;

	// Advance column, then scan line, then row; track the row's first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			line_q <= '0;
			row_q  <= '0;
			base_q <= '0;
		end else if (advance) begin
			if (col_q == tmcg_pkg::COL_W'(tmcg_pkg::COLUMNS - 1)) begin
				col_q <= '0;
				if (line_q == tmcg_pkg::LINE_W'(tmcg_pkg::LINES_PER_CHAR - 1)) begin
					line_q <= '0;
					if (row_q == tmcg_pkg::ROW_W'(tmcg_pkg::ROWS - 1)) begin
						row_q  <= '0;
						base_q <= '0;
					end else begin
						row_q  <= row_q + 1'b1;
						base_q <= base_q + tmcg_pkg::CELL_W'(tmcg_pkg::COLUMNS);
					end
				end else begin
					line_q <= line_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// Cell address is the row base plus the column
	assign pos.col       = col_q;
	assign pos.line      = line_q;
	assign pos.row       = row_q;
	assign pos.cell_addr = base_q + tmcg_pkg::CELL_W'(col_q);

endmodule

[src/text_mode_character_generator.sv]
`timescale 1ns / 1ps

// Text-mode character generator.
// Input channel (in_valid / in_stall): each item carries cmd, mem_addr and
// mem_data. cmd CMD_SCREEN writes a character code into screen memory,
// cmd CMD_GLYPH writes a pixel slice into glyph memory, cmd CMD_TICK asks for
// the slice at the current raster position; any other code is dropped.
// Output channel (out_valid / out_stall): one item per tick, carrying
// pixel_bits (bit 7 leftmost, inversion applied), char_column and pixel_row.
// Writes give no output item and never move the raster position.
// A tick passes through the screen read, the glyph read and the output register,
// in that order. Throughput is one item per cycle while not clearing and while
// the receiver does not stall; the rate is set by the two chained memory reads.
// When the receiver stalls, the output holds and the pipeline keeps filling;
// once the two internal stages and the output register are full, in_stall
// rises until the output is taken.
// After reset the screen memory is cleared one word a cycle, all 1024 words,
// during which in_stall is high. Glyph memory is not cleared.
module text_mode_character_generator (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tmcg_pkg::CMD_W-1:0]   cmd,
	input  logic [tmcg_pkg::ADDR_W-1:0]  mem_addr,
	input  logic [tmcg_pkg::DATA_W-1:0]  mem_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tmcg_pkg::DATA_W-1:0]  pixel_bits,
	output logic [tmcg_pkg::COL_W-1:0]   char_column,
	output logic [tmcg_pkg::PROW_W-1:0]  pixel_row
);

	logic                          clearing;
	logic [tmcg_pkg::CLR_W-1:0]    clr_q;
	logic                          accept;
	logic                          tick;
	logic                          en1;
	logic                          en2;
	logic                          out_ready;
	tmcg_pkg::pos_t                pos;

	logic                          scr_we;
	tmcg_pkg::screen_addr_t        scr_waddr;
	logic [tmcg_pkg::DATA_W-1:0]   scr_wdata;
	logic [tmcg_pkg::DATA_W-1:0]   scr_rdata;
	logic                          glyph_we;
	tmcg_pkg::glyph_addr_t         glyph_raddr;
	logic [tmcg_pkg::DATA_W-1:0]   glyph_rdata;
	logic [tmcg_pkg::DATA_W-1:0]   code;

	logic                          valid_s1;
	logic                          cell_ok_s1;
	logic [tmcg_pkg::LINE_W-1:0]   line_s1;
	logic [tmcg_pkg::COL_W-1:0]    col_s1;
	logic [tmcg_pkg::PROW_W-1:0]   prow_s1;
	logic                          valid_s2;
	logic                          inv_s2;
	logic [tmcg_pkg::COL_W-1:0]    col_s2;
	logic [tmcg_pkg::PROW_W-1:0]   prow_s2;
	logic                          out_valid_q;
	logic [tmcg_pkg::DATA_W-1:0]   pixel_q;
	logic [tmcg_pkg::COL_W-1:0]    col_q;
	logic [tmcg_pkg::PROW_W-1:0]   prow_q;

	// Stage enables: each stage moves when the one after it can take it
	assign out_ready = !out_valid_q || !out_stall;
	assign en2       = !valid_s2 || out_ready;
	assign en1       = !valid_s1 || en2;
	assign clearing  = 32'(clr_q) < tmcg_pkg::SCREEN_WORDS;
	assign in_stall  = clearing || !en1;
	assign accept    = in_valid && !in_stall;
	assign tick      = accept && (cmd == tmcg_pkg::CMD_TICK);

	// Sweep screen memory to zero after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	tmcg_raster u_raster (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (tick),
		.pos     (pos)
	);

	// Screen write port: clearing sweep, else write items within range
	always_comb begin
		if (clearing) begin
			scr_we    = 1'b1;
			scr_waddr = tmcg_pkg::screen_addr_t'(clr_q);
			scr_wdata = '0;
		end else begin
			scr_we    = accept && (cmd == tmcg_pkg::CMD_SCREEN)
			            && (32'(mem_addr) < tmcg_pkg::SCREEN_WORDS);
			scr_waddr = tmcg_pkg::screen_addr_t'(mem_addr);
			scr_wdata = mem_data;
		end
	end

	tmcg_ram #(
		.WIDTH (tmcg_pkg::DATA_W),
		.DEPTH (tmcg_pkg::SCREEN_WORDS)
	) u_screen_ram (
		.clk   (clk),
		.we    (scr_we),
		.waddr (scr_waddr),
		.wdata (scr_wdata),
		.re    (en1),
		.raddr (tmcg_pkg::screen_addr_t'(pos.cell_addr)),
		.rdata (scr_rdata)
	);

	// Cells beyond screen memory read as code zero
	assign code        = cell_ok_s1 ? scr_rdata : '0;
	assign glyph_raddr = tmcg_pkg::glyph_addr_t'({code[tmcg_pkg::GLYPH_SEL_W-1:0], line_s1});
	assign glyph_we    = accept && (cmd == tmcg_pkg::CMD_GLYPH)
	                     && (32'(mem_addr) < tmcg_pkg::GLYPH_WORDS);

	tmcg_ram #(
		.WIDTH (tmcg_pkg::DATA_W),
		.DEPTH (tmcg_pkg::GLYPH_WORDS)
	) u_glyph_ram (
		.clk   (clk),
		.we    (glyph_we),
		.waddr (tmcg_pkg::glyph_addr_t'(mem_addr)),
		.wdata (mem_data),
		.re    (en2),
		.raddr (glyph_raddr),
		.rdata (glyph_rdata)
	);

	// Stage valids and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) begin
				valid_s1 <= tick;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
			if (out_ready) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// Carry the position alongside the memory reads
	always_ff @(posedge clk) begin
		if (en1) begin
			cell_ok_s1 <= 32'(pos.cell_addr) < tmcg_pkg::SCREEN_WORDS;
			line_s1    <= pos.line;
			col_s1     <= pos.col;
			prow_s1    <= {pos.row, pos.line};
		end
		if (en2) begin
			inv_s2  <= code[tmcg_pkg::INVERT_BIT];
			col_s2  <= col_s1;
			prow_s2 <= prow_s1;
		end
		if (out_ready && valid_s2) begin
			pixel_q <= glyph_rdata ^ {tmcg_pkg::DATA_W{inv_s2}};
			col_q   <= col_s2;
			prow_q  <= prow_s2;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_bits  = pixel_q;
	assign char_column = col_q;
	assign pixel_row   = prow_q;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	localparam int          CLK_HALF      = 5;
	localparam int          RESET_CYCLES  = 7;
	localparam int          RANDOM_ITEMS  = 1150;
	localparam int          PRESSURE_AT   = 400;
	localparam int          PRESSURE_TICKS = 60;
	localparam int          LONG_HOLD     = 80;
	localparam int          SETTLE_CYCLES = 20;
	localparam int          MODE_PERIOD   = 300;
	localparam int unsigned RUN_LIMIT     = 1_000_000;
	localparam int          REPORT_MAX    = 10;

	// cmd code the block must drop
	localparam logic [tmcg_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum int {
		FLOW_FREE,
		FLOW_RANDOM,
		FLOW_EVERY_THIRD,
		FLOW_CHOKED
	} flow_t;

	typedef struct packed {
		logic [tmcg_pkg::DATA_W-1:0] pixels;
		logic [tmcg_pkg::COL_W-1:0]  column;
		logic [tmcg_pkg::PROW_W-1:0] prow;
	} slice_t;

	typedef struct packed {
		logic [tmcg_pkg::CMD_W-1:0]  op;
		logic [tmcg_pkg::ADDR_W-1:0] addr;
		logic [tmcg_pkg::DATA_W-1:0] data;
		logic                        typed;
		slice_t                      res;
	} step_t;

	logic                        clk         = 1'b0;
	logic                        arst_n      = 1'b0;
	logic                        in_valid    = 1'b0;
	logic                        in_stall;
	logic [tmcg_pkg::CMD_W-1:0]  cmd         = tmcg_pkg::CMD_TICK;
	logic [tmcg_pkg::ADDR_W-1:0] mem_addr    = '0;
	logic [tmcg_pkg::DATA_W-1:0] mem_data    = '0;
	logic                        out_valid;
	logic                        out_stall   = 1'b0;
	logic [tmcg_pkg::DATA_W-1:0] pixel_bits;
	logic [tmcg_pkg::COL_W-1:0]  char_column;
	logic [tmcg_pkg::PROW_W-1:0] pixel_row;

	text_mode_character_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.mem_addr    (mem_addr),
		.mem_data    (mem_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pixel_bits  (pixel_bits),
		.char_column (char_column),
		.pixel_row   (pixel_row)
	);

	// Shadow of the block: memories and raster position
	logic [tmcg_pkg::DATA_W-1:0] screen_image [tmcg_pkg::SCREEN_WORDS] = '{default: '0};
	logic [tmcg_pkg::DATA_W-1:0] glyph_image  [tmcg_pkg::GLYPH_WORDS]  = '{default: '0};
	bit                          glyph_known  [tmcg_pkg::GLYPH_WORDS]  = '{default: 1'b0};
	logic [tmcg_pkg::COL_W-1:0]  col_pos  = '0;
	logic [tmcg_pkg::LINE_W-1:0] line_pos = '0;
	logic [tmcg_pkg::ROW_W-1:0]  row_pos  = '0;

	slice_t      expected_slices [$];
	int          failures     = 0;
	int unsigned cycles_run   = 0;
	int          burst_left   = 8;
	int          holds_asked  = 0;
	int          holds_served = 0;
	int          hold_left    = 0;
	flow_t       flow_mode    = FLOW_FREE;

	// Directed items: extremes, inversion, dropped command, out-of-range writes
	step_t directed_steps [18] = '{
		'{tmcg_pkg::CMD_GLYPH,  11'd0,    8'hA5, 1'b0, '0},
		'{tmcg_pkg::CMD_TICK,   11'd0,    8'h00, 1'b1, '{8'hA5, 6'd0, 8'd0}},
		'{tmcg_pkg::CMD_SCREEN, 11'd1,    8'h80, 1'b0, '0},
		'{tmcg_pkg::CMD_TICK,   11'd0,    8'h00, 1'b1, '{8'h5A, 6'd1, 8'd0}},
		'{tmcg_pkg::CMD_SCREEN, 11'd2,    8'hFF, 1'b0, '0},
		'{tmcg_pkg::CMD_GLYPH,  11'd1016, 8'h00, 1'b0, '0},
		'{tmcg_pkg::CMD_TICK,   11'd0,    8'h00, 1'b1, '{8'hFF, 6'd2, 8'd0}},
		'{tmcg_pkg::CMD_SCREEN, 11'd3,    8'h7F, 1'b0, '0},
		'{tmcg_pkg::CMD_TICK,   11'd0,    8'h00, 1'b1, '{8'h00, 6'd3, 8'd0}},
		'{CMD_UNUSED,           11'd4,    8'hFF, 1'b0, '0},
		'{tmcg_pkg::CMD_TICK,   11'd0,    8'h00, 1'b1, '{8'hA5, 6'd4, 8'd0}},
		'{tmcg_pkg::CMD_SCREEN, 11'd1029, 8'h80, 1'b0, '0},
		'{tmcg_pkg::CMD_TICK,   11'd0,    8'h00, 1'b1, '{8'hA5, 6'd5, 8'd0}},
		'{tmcg_pkg::CMD_GLYPH,  11'd2047, 8'hFF, 1'b0, '0},
		'{tmcg_pkg::CMD_SCREEN, 11'd1023, 8'h55, 1'b0, '0},
		'{tmcg_pkg::CMD_GLYPH,  11'd7,    8'h3C, 1'b0, '0},
		'{tmcg_pkg::CMD_TICK,   11'd2047, 8'hFF, 1'b1, '{8'hA5, 6'd6, 8'd0}},
		'{tmcg_pkg::CMD_GLYPH,  11'd1,    8'h81, 1'b0, '0}
	};

	always #CLK_HALF clk = ~clk;

	// Glyph word the next tick will fetch
	function automatic tmcg_pkg::glyph_addr_t next_glyph_addr();
		int                          cell_no;
		logic [tmcg_pkg::DATA_W-1:0] code;
		cell_no = int'(row_pos) * tmcg_pkg::COLUMNS + int'(col_pos);
		code = (cell_no < tmcg_pkg::SCREEN_WORDS) ? screen_image[cell_no] : '0;
		return tmcg_pkg::glyph_addr_t'({code[tmcg_pkg::GLYPH_SEL_W-1:0], line_pos});
	endfunction

	// Apply one item to the shadow; return 1 with the slice for a tick
	function automatic bit raster_model_step(input logic [tmcg_pkg::CMD_W-1:0] op,
			input logic [tmcg_pkg::ADDR_W-1:0] addr,
			input logic [tmcg_pkg::DATA_W-1:0] data,
			output slice_t res);
		int                          cell_no;
		logic [tmcg_pkg::DATA_W-1:0] code;
		res = '0;
		case (op)
			tmcg_pkg::CMD_SCREEN: begin
				if (addr < tmcg_pkg::SCREEN_WORDS)
					screen_image[addr] = data;
				return 1'b0;
			end
			tmcg_pkg::CMD_GLYPH: begin
				if (addr < tmcg_pkg::GLYPH_WORDS) begin
					glyph_image[addr] = data;
					glyph_known[addr] = 1'b1;
				end
				return 1'b0;
			end
			tmcg_pkg::CMD_TICK: begin
				cell_no = int'(row_pos) * tmcg_pkg::COLUMNS + int'(col_pos);
				code = (cell_no < tmcg_pkg::SCREEN_WORDS) ? screen_image[cell_no] : '0;
				res.pixels = glyph_image[next_glyph_addr()];
				if (code[tmcg_pkg::INVERT_BIT])
					res.pixels = ~res.pixels;
				res.column = col_pos;
				res.prow   = {row_pos, line_pos};
				// advance column, then scan line, then row
				if (int'(col_pos) == tmcg_pkg::COLUMNS - 1) begin
					col_pos = '0;
					if (int'(line_pos) == tmcg_pkg::LINES_PER_CHAR - 1) begin
						line_pos = '0;
						row_pos  = (int'(row_pos) == tmcg_pkg::ROWS - 1) ? '0
						                                                 : row_pos + 1'b1;
					end else begin
						line_pos = line_pos + 1'b1;
					end
				end else begin
					col_pos = col_pos + 1'b1;
				end
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// Close a burst with a random gap, then pick the next burst length
	task automatic pace();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
			                                         : $urandom_range(1, 12);
		end
	endtask

	// Offer one item, hold it until taken, then predict
	task automatic offer(input logic [tmcg_pkg::CMD_W-1:0] op,
			input logic [tmcg_pkg::ADDR_W-1:0] addr,
			input logic [tmcg_pkg::DATA_W-1:0] data, input logic typed,
			input slice_t typed_res);
		slice_t predicted;
		in_valid <= 1'b1;
		cmd      <= op;
		mem_addr <= addr;
		mem_data <= data;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (raster_model_step(op, addr, data, predicted))
			expected_slices.push_back(typed ? typed_res : predicted);
		pace();
	endtask

	// Tick, first writing the glyph word it reads if that word is still unset
	task automatic tick(input logic [tmcg_pkg::ADDR_W-1:0] addr,
			input logic [tmcg_pkg::DATA_W-1:0] data,
			input logic typed, input slice_t typed_res);
		tmcg_pkg::glyph_addr_t gaddr;
		gaddr = next_glyph_addr();
		if (!glyph_known[gaddr])
			offer(tmcg_pkg::CMD_GLYPH, gaddr, tmcg_pkg::DATA_W'($urandom), 1'b0, '0);
		offer(tmcg_pkg::CMD_TICK, addr, data, typed, typed_res);
	endtask

	task automatic random_tick();
		tick(tmcg_pkg::ADDR_W'($urandom), tmcg_pkg::DATA_W'($urandom), 1'b0, '0);
	endtask

	// Drop valid and wait for every outstanding slice
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_slices.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_item();
		int                          pick;
		int                          where;
		logic [tmcg_pkg::ADDR_W-1:0] addr;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			random_tick();
		end else if (pick < 72) begin
			// mostly aim at the row being scanned so writes are seen
			where = $urandom_range(0, 9);
			if (where < 6)
				addr = tmcg_pkg::ADDR_W'(int'(row_pos) * tmcg_pkg::COLUMNS
				       + $urandom_range(0, tmcg_pkg::COLUMNS - 1));
			else if (where < 8)
				addr = tmcg_pkg::ADDR_W'($urandom_range(0, tmcg_pkg::SCREEN_WORDS - 1));
			else
				addr = tmcg_pkg::ADDR_W'($urandom_range(tmcg_pkg::SCREEN_WORDS,
				       (1 << tmcg_pkg::ADDR_W) - 1));
			offer(tmcg_pkg::CMD_SCREEN, addr, tmcg_pkg::DATA_W'($urandom), 1'b0, '0);
		end else if (pick < 95) begin
			offer(tmcg_pkg::CMD_GLYPH, tmcg_pkg::ADDR_W'($urandom),
			      tmcg_pkg::DATA_W'($urandom), 1'b0, '0);
		end else begin
			offer(CMD_UNUSED, tmcg_pkg::ADDR_W'($urandom), tmcg_pkg::DATA_W'($urandom),
			      1'b0, '0);
		end
	endtask

	// Stimulus
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_steps[i]) begin
			if (directed_steps[i].op == tmcg_pkg::CMD_TICK)
				tick(directed_steps[i].addr, directed_steps[i].data,
				     directed_steps[i].typed, directed_steps[i].res);
			else
				offer(directed_steps[i].op, directed_steps[i].addr, directed_steps[i].data,
				      1'b0, '0);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == PRESSURE_AT) begin
				// hold the receiver off while ticks keep coming, then let it drain
				holds_asked++;
				burst_left = 4 * PRESSURE_TICKS;
				repeat (PRESSURE_TICKS) random_tick();
				drain();
			end
			random_item();
		end

		repeat (50) random_item();

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	function automatic void note_failure(input string what, input slice_t want,
			input slice_t got);
		failures++;
		if (failures <= REPORT_MAX)
			$display("%s: expected pixels %02h column %0d row %0d, got pixels %02h column %0d row %0d",
			         what, want.pixels, want.column, want.prow,
			         got.pixels, got.column, got.prow);
	endfunction

	// Receiver: check taken slices, then choose the next stall
	always @(posedge clk) begin
		slice_t got;
		slice_t want;
		got = '{pixel_bits, char_column, pixel_row};
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (expected_slices.size() == 0) begin
				note_failure("unexpected slice", '0, got);
			end else begin
				want = expected_slices.pop_front();
				if (got.pixels !== want.pixels || got.column !== want.column ||
				    got.prow !== want.prow)
					note_failure("slice mismatch", want, got);
			end
		end

		if (cycles_run % MODE_PERIOD == 0)
			flow_mode = flow_t'($urandom_range(0, 3));

		if (hold_left == 0 && holds_served != holds_asked) begin
			holds_served++;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			case (flow_mode)
				FLOW_FREE:        out_stall <= 1'b0;
				FLOW_RANDOM:      out_stall <= ($urandom_range(0, 9) < 3);
				FLOW_EVERY_THIRD: out_stall <= (cycles_run % 3 != 0);
				default:          out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles_run++;
		if (cycles_run >= RUN_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

endmodule
